// ===== rtl/cache_set_lru_mru_space_budget_defines.svh =====
// Assertion macros for the cache set replacement block.
// Taken in by the top level; relies on nothing else.
`ifndef CACHE_SET_LRU_MRU_SPACE_BUDGET_DEFINES_SVH
`define CACHE_SET_LRU_MRU_SPACE_BUDGET_DEFINES_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define CSLRU_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define CSLRU_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/cslru_pkg.sv =====
// Shared types and codes for the cache set replacement block.
// No dependencies; used by the controller, the datapath and the top level.
`default_nettype none

package cslru_pkg;

  // Result kinds
  localparam logic [1:0] KIND_EVICT  = 2'd0;
  localparam logic [1:0] KIND_HIT    = 2'd1;
  localparam logic [1:0] KIND_INSERT = 2'd2;
  localparam logic [1:0] KIND_REJECT = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_POLICY      = 2'd0;
  localparam logic [1:0] CFG_SPACE_LIMIT = 2'd1;
  localparam logic [1:0] CFG_WAYS_IN_USE = 2'd2;

  // Fixed field widths
  localparam int SPACE_W    = 40;
  localparam int SIZE_W     = 32;
  localparam int KEY_PORT_W = 32;
  localparam int CNT_PORT_W = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 40;

  // Controller to datapath commands
  typedef struct packed {
    logic start;
    logic scan;
    logic vic_latch;
    logic do_hit;
    logic do_evict;
    logic do_insert;
    logic do_reject;
  } cslru_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic hit;
    logic scan_done;
    logic need_evict;
    logic empty;
    logic out_free;
  } cslru_sts_t;

endpackage

`default_nettype wire

// ===== rtl/cache_set_lru_mru_space_budget.sv =====
// One fully associative cache set with LRU or MRU replacement under an entry
// limit and a space budget. Each access is taken in the idle state, then the key
// memory is scanned one way per cycle: a hit is committed from the hit state
// once the result register is free; a miss scans every way, then evicts until
// the object fits, each eviction latching the victim and then committing, and
// ends with the insert or the rejection. The next access is taken once the last
// result beat of the current one sits in the output register. Each eviction
// gives one beat with last low; the access ends with a hit, insert or reject
// beat with last high. No clearing pass follows reset.
// Depends on cslru_pkg, cslru_ctrl, cslru_dp and the assertion macro header.
`default_nettype none
`include "cache_set_lru_mru_space_budget_defines.svh"

module cache_set_lru_mru_space_budget import cslru_pkg::*; #(
  parameter int WAYS     = 16,
  parameter int KEY_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [KEY_PORT_W-1:0] in_key,
  input  logic [SIZE_W-1:0]     in_object_size,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            out_kind,
  output logic [KEY_PORT_W-1:0] out_evicted_key,
  output logic [SIZE_W-1:0]     out_evicted_size,
  output logic [SPACE_W-1:0]    out_space_now,
  output logic [CNT_PORT_W-1:0] out_entries_now,
  output logic                  out_last
);

  cslru_cmd_t cmd;
  cslru_sts_t sts;

  // Sequencer
  cslru_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Storage and arithmetic
  cslru_dp #(
    .WAYS     (WAYS),
    .KEY_BITS (KEY_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_key           (in_key),
    .in_object_size   (in_object_size),
    .cmd              (cmd),
    .sts              (sts),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .out_kind         (out_kind),
    .out_evicted_key  (out_evicted_key),
    .out_evicted_size (out_evicted_size),
    .out_space_now    (out_space_now),
    .out_entries_now  (out_entries_now),
    .out_last         (out_last)
  );

  // At most one state commit per cycle
  `CSLRU_ASSERT_IMP(a_one_commit, clk, rst_n, 1'b1, $onehot0({cmd.do_hit, cmd.do_evict, cmd.do_insert, cmd.do_reject}), "more than one commit in a cycle")

  // A commit never overwrites a result beat that is still waiting
  `CSLRU_ASSERT_IMP(a_commit_slot, clk, rst_n, cmd.do_hit || cmd.do_evict || cmd.do_insert || cmd.do_reject, sts.out_free, "commit while result register is full")

  // An eviction shows up next cycle as a non-final eviction beat
  `CSLRU_ASSERT_NXT(a_evict_beat, clk, rst_n, cmd.do_evict, out_valid && (out_kind == KIND_EVICT) && !out_last, "eviction beat missing")

  // A final commit returns the block to taking new accesses
  `CSLRU_ASSERT_NXT(a_back_idle, clk, rst_n, cmd.do_hit || cmd.do_insert || cmd.do_reject, in_ready && out_valid && out_last, "access did not finish")

endmodule

`default_nettype wire

// ===== rtl/cslru_ctrl.sv =====
// Sequencer of the cache set: lookup scan, eviction loop, insert or reject.
// Depends on cslru_pkg for the command and status structs.
`default_nettype none

module cslru_ctrl import cslru_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  cslru_sts_t sts,
  output cslru_cmd_t cmd
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCAN  = 3'd1;
  localparam logic [2:0] ST_HIT   = 3'd2;
  localparam logic [2:0] ST_EVAL  = 3'd3;
  localparam logic [2:0] ST_EVICT = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  // Decode next state and commands
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.hit) begin
          state_nxt = ST_HIT;
        end else if (sts.scan_done) begin
          state_nxt = ST_EVAL;
        end
      end
      ST_HIT: begin
        if (sts.out_free) begin
          cmd.do_hit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      ST_EVAL: begin
        if (sts.need_evict) begin
          if (sts.empty) begin
            if (sts.out_free) begin
              cmd.do_reject = 1'b1;
              state_nxt     = ST_IDLE;
            end
          end else begin
            cmd.vic_latch = 1'b1;
            state_nxt     = ST_EVICT;
          end
        end else if (sts.out_free) begin
          cmd.do_insert = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_EVICT: begin
        if (sts.out_free) begin
          cmd.do_evict = 1'b1;
          state_nxt    = ST_EVAL;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Advance state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/cslru_dp.sv =====
// Datapath of the cache set: key and size memories, per-way valid and age rank,
// occupancy, configuration and the result register. Depends on cslru_pkg.
`default_nettype none

module cslru_dp import cslru_pkg::*; #(
  parameter int WAYS     = 16,
  parameter int KEY_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic [KEY_PORT_W-1:0] in_key,
  input  logic [SIZE_W-1:0]     in_object_size,
  input  cslru_cmd_t            cmd,
  output cslru_sts_t            sts,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [1:0]            out_kind,
  output logic [KEY_PORT_W-1:0] out_evicted_key,
  output logic [SIZE_W-1:0]     out_evicted_size,
  output logic [SPACE_W-1:0]    out_space_now,
  output logic [CNT_PORT_W-1:0] out_entries_now,
  output logic                  out_last
);

  localparam int IW = $clog2(WAYS);
  localparam int RW = IW;
  localparam int CW = $clog2(WAYS + 1);
  localparam int KW = (KEY_BITS < KEY_PORT_W) ? KEY_BITS : KEY_PORT_W;
  localparam int LW = (CW > CNT_PORT_W) ? CW : CNT_PORT_W;
  localparam logic [IW:0] WAYS_C = (IW + 1)'(WAYS);

  // Configuration
  logic                  policy_r;
  logic [SPACE_W-1:0]    space_limit_r;
  logic [CNT_PORT_W-1:0] ways_r;

  // Per-way state
  logic [WAYS-1:0] valid_r;
  logic [WAYS-1:0] valid_nxt;
  logic [RW-1:0]   rank_r   [WAYS];
  logic [RW-1:0]   rank_nxt [WAYS];

  // Occupancy
  logic [SPACE_W-1:0] space_r;
  logic [CW-1:0]      n_r;

  // Request
  logic [KW-1:0]     req_key_r;
  logic [SIZE_W-1:0] req_size_r;

  // Memories
  logic [KW-1:0]     key_mem  [WAYS];
  logic [SIZE_W-1:0] size_mem [WAYS];
  logic [KW-1:0]     rd_key_r;
  logic [SIZE_W-1:0] rd_size_r;
  logic              mem_re;
  logic [IW-1:0]     rd_addr;

  // Scan and victim tracking
  logic [IW:0]   scan_addr_r;
  logic          cmp_v_r;
  logic [IW-1:0] cmp_idx_r;
  logic [IW-1:0] hit_idx_r;
  logic [IW-1:0] free_idx_r;
  logic          free_ok_r;
  logic [IW-1:0] vic_idx_r;
  logic [RW-1:0] vic_rank_r;
  logic [WAYS-1:0] vic_match;
  logic [IW-1:0] vic_enc;
  logic [RW-1:0] want;
  logic [RW-1:0] hit_rank;
  logic          cmp_valid;

  // Arithmetic
  logic [CW-1:0]      n_inc;
  logic [CW-1:0]      n_dec;
  logic [LW-1:0]      n_ext;
  logic [LW-1:0]      ways_ext;
  logic [LW-1:0]      lim;
  logic [SPACE_W:0]   space_sum;
  logic [SPACE_W-1:0] space_ins;
  logic [SPACE_W-1:0] space_sub;

  // Result register
  logic                  out_valid_r;
  logic [1:0]            out_kind_r;
  logic [KEY_PORT_W-1:0] out_key_r;
  logic [SIZE_W-1:0]     out_size_r;
  logic [SPACE_W-1:0]    out_space_r;
  logic [CNT_PORT_W-1:0] out_entries_r;
  logic                  out_last_r;
  logic                  emit;
  logic [1:0]            kind_nxt;
  logic [KEY_PORT_W-1:0] key_nxt;
  logic [SIZE_W-1:0]     size_nxt;
  logic [SPACE_W-1:0]    space_nxt;
  logic [CNT_PORT_W-1:0] entries_nxt;
  logic                  last_nxt;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r      <= 1'b0;
      space_limit_r <= '1;
      ways_r        <= 5'd16;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_POLICY:      policy_r      <= cfg_wdata[0];
        CFG_SPACE_LIMIT: space_limit_r <= cfg_wdata[SPACE_W-1:0];
        CFG_WAYS_IN_USE: ways_r        <= cfg_wdata[CNT_PORT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Count and space arithmetic
  assign n_inc     = n_r + 1'b1;
  assign n_dec     = n_r - 1'b1;
  assign n_ext     = LW'(n_r);
  assign ways_ext  = LW'(ways_r);
  assign lim       = (ways_ext == '0) ? LW'(1) :
                     ((ways_ext > LW'(WAYS)) ? LW'(WAYS) : ways_ext);
  assign space_sum = {1'b0, space_r} + (SPACE_W + 1)'(req_size_r);
  assign space_ins = space_r + SPACE_W'(req_size_r);
  assign space_sub = (space_r >= SPACE_W'(rd_size_r)) ? space_r - SPACE_W'(rd_size_r) : '0;

  // Victim: the valid way whose rank matches the policy's end of the order
  assign want = policy_r ? '0 : RW'(n_dec);

  always_comb begin
    vic_enc = '0;
    for (int j = 0; j < WAYS; j++) begin
      vic_match[j] = valid_r[j] && (rank_r[j] == want);
      if (vic_match[j]) begin
        vic_enc = vic_enc | IW'(j);
      end
    end
  end

  // Status to the controller
  assign cmp_valid      = valid_r[cmp_idx_r];
  assign hit_rank       = rank_r[hit_idx_r];
  assign sts.hit        = cmp_v_r && cmp_valid && (rd_key_r == req_key_r);
  assign sts.scan_done  = (scan_addr_r == WAYS_C) && !cmp_v_r;
  assign sts.need_evict = (n_ext >= lim) || (space_sum > {1'b0, space_limit_r});
  assign sts.empty      = (n_r == '0);
  assign sts.out_free   = !out_valid_r || out_ready;

  // Latch the request
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      req_key_r  <= in_key[KW-1:0];
      req_size_r <= in_object_size;
    end
  end

  // Step the lookup scan, track the hit way and the lowest free way
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_addr_r <= '0;
      cmp_v_r     <= 1'b0;
      free_ok_r   <= 1'b0;
    end else if (cmd.start) begin
      scan_addr_r <= '0;
      cmp_v_r     <= 1'b0;
      free_ok_r   <= 1'b0;
    end else if (cmd.scan) begin
      if (scan_addr_r < WAYS_C) begin
        scan_addr_r <= scan_addr_r + 1'b1;
        cmp_v_r     <= 1'b1;
        cmp_idx_r   <= scan_addr_r[IW-1:0];
      end else begin
        cmp_v_r <= 1'b0;
      end
      if (sts.hit) begin
        hit_idx_r <= cmp_idx_r;
      end
      if (cmp_v_r && !cmp_valid && !free_ok_r) begin
        free_idx_r <= cmp_idx_r;
        free_ok_r  <= 1'b1;
      end
    end else if (cmd.do_evict) begin
      if (!free_ok_r || (vic_idx_r < free_idx_r)) begin
        free_idx_r <= vic_idx_r;
        free_ok_r  <= 1'b1;
      end
    end
  end

  // Hold the chosen victim
  always_ff @(posedge clk) begin
    if (cmd.vic_latch) begin
      vic_idx_r  <= vic_enc;
      vic_rank_r <= want;
    end
  end

  // Key and size memories: one write, one registered read
  assign mem_re  = cmd.vic_latch || (cmd.scan && (scan_addr_r < WAYS_C));
  assign rd_addr = cmd.vic_latch ? vic_enc : scan_addr_r[IW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.do_insert) begin
      key_mem[free_idx_r]  <= req_key_r;
      size_mem[free_idx_r] <= req_size_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_key_r  <= key_mem[rd_addr];
      rd_size_r <= size_mem[rd_addr];
    end
  end

  // Update valid bits and age ranks lane by lane
  always_comb begin
    valid_nxt = valid_r;
    for (int j = 0; j < WAYS; j++) begin
      rank_nxt[j] = rank_r[j];
      if (cmd.do_hit) begin
        if (IW'(j) == hit_idx_r) begin
          rank_nxt[j] = '0;
        end else if (valid_r[j] && (rank_r[j] < hit_rank)) begin
          rank_nxt[j] = rank_r[j] + 1'b1;
        end
      end
      if (cmd.do_evict) begin
        if (IW'(j) == vic_idx_r) begin
          valid_nxt[j] = 1'b0;
          rank_nxt[j]  = '0;
        end else if (valid_r[j] && (rank_r[j] > vic_rank_r)) begin
          rank_nxt[j] = rank_r[j] - 1'b1;
        end
      end
      if (cmd.do_insert) begin
        if (IW'(j) == free_idx_r) begin
          valid_nxt[j] = 1'b1;
          rank_nxt[j]  = '0;
        end else if (valid_r[j]) begin
          rank_nxt[j] = rank_r[j] + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      for (int j = 0; j < WAYS; j++) begin
        rank_r[j] <= '0;
      end
    end else begin
      valid_r <= valid_nxt;
      for (int j = 0; j < WAYS; j++) begin
        rank_r[j] <= rank_nxt[j];
      end
    end
  end

  // Track occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      space_r <= '0;
      n_r     <= '0;
    end else if (cmd.do_evict) begin
      space_r <= space_sub;
      n_r     <= n_dec;
    end else if (cmd.do_insert) begin
      space_r <= space_ins;
      n_r     <= n_inc;
    end
  end

  // Form the result beat
  assign emit = cmd.do_hit || cmd.do_evict || cmd.do_insert || cmd.do_reject;

  always_comb begin
    kind_nxt    = KIND_HIT;
    key_nxt     = '0;
    size_nxt    = '0;
    space_nxt   = space_r;
    entries_nxt = CNT_PORT_W'(n_r);
    last_nxt    = 1'b1;
    if (cmd.do_evict) begin
      kind_nxt    = KIND_EVICT;
      key_nxt     = KEY_PORT_W'(rd_key_r);
      size_nxt    = rd_size_r;
      space_nxt   = space_sub;
      entries_nxt = CNT_PORT_W'(n_dec);
      last_nxt    = 1'b0;
    end else if (cmd.do_insert) begin
      kind_nxt    = KIND_INSERT;
      space_nxt   = space_ins;
      entries_nxt = CNT_PORT_W'(n_inc);
    end else if (cmd.do_reject) begin
      kind_nxt = KIND_REJECT;
    end
  end

  // Hold the result beat until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_kind_r    <= kind_nxt;
      out_key_r     <= key_nxt;
      out_size_r    <= size_nxt;
      out_space_r   <= space_nxt;
      out_entries_r <= entries_nxt;
      out_last_r    <= last_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_evicted_key  = out_key_r;
  assign out_evicted_size = out_size_r;
  assign out_space_now    = out_space_r;
  assign out_entries_now  = out_entries_r;
  assign out_last         = out_last_r;

endmodule

`default_nettype wire

// ===== bench/cache_set_replacement_checker.sv =====
`timescale 1ns / 100ps
// Checker for the cache set replacement block: tracks the set contents,
// predicts every result beat and compares it with the output channel.
// Depends on cslru_pkg for field widths, result kinds and register indexes.

module cache_set_replacement_checker import cslru_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [KEY_PORT_W-1:0] in_key,
  input  logic [SIZE_W-1:0]     in_object_size,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [1:0]            out_kind,
  input  logic [KEY_PORT_W-1:0] out_evicted_key,
  input  logic [SIZE_W-1:0]     out_evicted_size,
  input  logic [SPACE_W-1:0]    out_space_now,
  input  logic [CNT_PORT_W-1:0] out_entries_now,
  input  logic                  out_last,
  output int                    mismatches,
  output int                    beats_pending
);

  localparam int WAYS = 16;

  typedef struct packed {
    logic [1:0]            kind;
    logic [KEY_PORT_W-1:0] key;
    logic [SIZE_W-1:0]     size;
    logic [SPACE_W-1:0]    space;
    logic [CNT_PORT_W-1:0] entries;
    logic                  last;
  } beat_t;

  beat_t expected_beats[$];
  beat_t oldest_beat;

  // Shadow copy of the set and its settings
  logic [KEY_PORT_W-1:0] way_key   [WAYS];
  logic [SIZE_W-1:0]     way_size  [WAYS];
  logic                  way_valid [WAYS];
  int                    way_rank  [WAYS];
  logic [SPACE_W-1:0]    stored_total;
  logic                  evict_newest;
  logic [SPACE_W-1:0]    space_budget;
  logic [4:0]            way_limit_reg;

  function automatic int occupied();
    int n;
    n = 0;
    for (int i = 0; i < WAYS; i++)
      if (way_valid[i]) n++;
    return n;
  endfunction

  task automatic post_beat(input logic [1:0] kind, input logic [KEY_PORT_W-1:0] k,
                           input logic [SIZE_W-1:0] s, input logic last);
    beat_t b;
    b.kind    = kind;
    b.key     = k;
    b.size    = s;
    b.space   = stored_total;
    b.entries = CNT_PORT_W'(occupied());
    b.last    = last;
    expected_beats.push_back(b);
  endtask

  // Drop the oldest (LRU) or newest (MRU) entry and close the rank gap
  task automatic evict_victim(input int n);
    int want, victim, r;
    logic [KEY_PORT_W-1:0] vk;
    logic [SIZE_W-1:0] vs;
    want = evict_newest ? 0 : n - 1;
    victim = 0;
    for (int i = WAYS - 1; i >= 0; i--)
      if (way_valid[i] && way_rank[i] == want) victim = i;
    r  = way_rank[victim];
    vk = way_key[victim];
    vs = way_size[victim];
    way_valid[victim] = 1'b0;
    way_rank[victim]  = 0;
    for (int i = 0; i < WAYS; i++)
      if (way_valid[i] && way_rank[i] > r) way_rank[i]--;
    stored_total = (stored_total >= SPACE_W'(vs)) ? stored_total - SPACE_W'(vs) : '0;
    post_beat(KIND_EVICT, vk, vs, 1'b0);
  endtask

  task automatic predict_access(input logic [KEY_PORT_W-1:0] key,
                                input logic [SIZE_W-1:0] osize);
    int hit_way, cap, n, slot, r;
    hit_way = -1;
    for (int i = 0; i < WAYS; i++)
      if (hit_way < 0 && way_valid[i] && way_key[i] == key) hit_way = i;

    // Hit: promote to newest, evict nothing
    if (hit_way >= 0) begin
      r = way_rank[hit_way];
      for (int j = 0; j < WAYS; j++)
        if (way_valid[j] && way_rank[j] < r) way_rank[j]++;
      way_rank[hit_way] = 0;
      post_beat(KIND_HIT, '0, '0, 1'b1);
      return;
    end

    // Miss: clamp the entry limit, then evict until the object fits
    cap = int'(way_limit_reg);
    if (cap < 1) cap = 1;
    if (cap > WAYS) cap = WAYS;
    n = occupied();
    while (n >= cap ||
           ({1'b0, stored_total} + (SPACE_W + 1)'(osize)) > {1'b0, space_budget}) begin
      if (n == 0) begin
        post_beat(KIND_REJECT, '0, '0, 1'b1);
        return;
      end
      evict_victim(n);
      n--;
    end

    // Insert as newest in the first free way
    for (int i = 0; i < WAYS; i++)
      if (way_valid[i]) way_rank[i]++;
    slot = -1;
    for (int i = 0; i < WAYS; i++)
      if (slot < 0 && !way_valid[i]) slot = i;
    way_valid[slot] = 1'b1;
    way_key[slot]   = key;
    way_size[slot]  = osize;
    way_rank[slot]  = 0;
    stored_total    = stored_total + SPACE_W'(osize);
    post_beat(KIND_INSERT, '0, '0, 1'b1);
  endtask

  task automatic compare_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s expected %0h, got %0h", $time, field, want, got);
    end
  endtask

  // Check result beats first: a beat leaving never belongs to an access taken
  // at the same edge
  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WAYS; i++) begin
        way_key[i]   = '0;
        way_size[i]  = '0;
        way_valid[i] = 1'b0;
        way_rank[i]  = 0;
      end
      stored_total  = '0;
      evict_newest  = 1'b0;
      space_budget  = '1;
      way_limit_reg = 5'd16;
      expected_beats.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_beats.size() == 0) begin
          mismatches++;
          $display("%0t: beat expected none, got kind %0h key %0h size %0h", $time,
                   out_kind, out_evicted_key, out_evicted_size);
        end else begin
          oldest_beat = expected_beats.pop_front();
          compare_field("kind", 64'(oldest_beat.kind), 64'(out_kind));
          compare_field("evicted_key", 64'(oldest_beat.key), 64'(out_evicted_key));
          compare_field("evicted_size", 64'(oldest_beat.size), 64'(out_evicted_size));
          compare_field("space_now", 64'(oldest_beat.space), 64'(out_space_now));
          compare_field("entries_now", 64'(oldest_beat.entries), 64'(out_entries_now));
          compare_field("last", 64'(oldest_beat.last), 64'(out_last));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_POLICY:      evict_newest  = cfg_wdata[0];
          CFG_SPACE_LIMIT: space_budget  = cfg_wdata[SPACE_W-1:0];
          CFG_WAYS_IN_USE: way_limit_reg = cfg_wdata[4:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) predict_access(in_key, in_object_size);
    end
    beats_pending = expected_beats.size();
  end

endmodule

// ===== bench/cache_set_lru_mru_space_budget_tb.sv =====
`timescale 1ns / 100ps
// Top of the cache set replacement testbench: clock, reset, settings and
// access stimulus, with the checker beside the block. Needs cslru_pkg, the
// block and cache_set_replacement_checker.

module cache_set_lru_mru_space_budget_tb;
  import cslru_pkg::*;

  localparam int RUN_LIMIT       = 1_000_000;
  localparam int SETTLE_CYCLES   = 64;
  localparam int RANDOM_ACCESSES = 450;
  localparam int PHASE_LEN       = 50;
  localparam int KEY_POOL        = 24;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_ready;
  logic [KEY_PORT_W-1:0] in_key;
  logic [SIZE_W-1:0]     in_object_size;
  logic                  out_valid;
  logic                  out_ready;
  logic [1:0]            out_kind;
  logic [KEY_PORT_W-1:0] out_evicted_key;
  logic [SIZE_W-1:0]     out_evicted_size;
  logic [SPACE_W-1:0]    out_space_now;
  logic [CNT_PORT_W-1:0] out_entries_now;
  logic                  out_last;

  int mismatches;
  int beats_pending;
  int cycles        = 0;
  int send_idle_pct = 29;
  int recv_idle_pct = 72;
  int roll;

  logic [KEY_PORT_W-1:0] key_pool [KEY_POOL];
  logic [SPACE_W-1:0]    budget_now;
  logic [SPACE_W-1:0]    budget_pick;
  logic [4:0]            limit_pick;

  cache_set_lru_mru_space_budget u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_key           (in_key),
    .in_object_size   (in_object_size),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_evicted_key  (out_evicted_key),
    .out_evicted_size (out_evicted_size),
    .out_space_now    (out_space_now),
    .out_entries_now  (out_entries_now),
    .out_last         (out_last)
  );

  cache_set_replacement_checker u_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_key           (in_key),
    .in_object_size   (in_object_size),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_evicted_key  (out_evicted_key),
    .out_evicted_size (out_evicted_size),
    .out_space_now    (out_space_now),
    .out_entries_now  (out_entries_now),
    .out_last         (out_last),
    .mismatches       (mismatches),
    .beats_pending    (beats_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Bound the run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == RUN_LIMIT) begin
      $display("cache_set_lru_mru_space_budget_tb: errors");
      $finish;
    end
  end

  // Stall the result channel at random
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Present one access beat; hold valid high on return
  task automatic send_access(input logic [KEY_PORT_W-1:0] key,
                             input logic [SIZE_W-1:0] osize);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_key         <= key;
    in_object_size <= osize;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Lower valid and wait for every predicted beat to leave
  task automatic drain();
    in_valid <= 1'b0;
    while (beats_pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
  endtask

  // Write all three registers; pad unused upper bits with noise
  task automatic apply_settings(input logic pol, input logic [SPACE_W-1:0] budget,
                                input logic [4:0] ways);
    logic [CFG_DATA_W-1:0] noise;
    noise = {8'($urandom()), 32'($urandom())};
    write_reg(CFG_POLICY, {noise[CFG_DATA_W-1:1], pol});
    write_reg(CFG_SPACE_LIMIT, budget);
    write_reg(CFG_WAYS_IN_USE, {noise[CFG_DATA_W-1:5], ways});
    cfg_we     <= 1'b0;
    budget_now  = budget;
  endtask

  function automatic logic [KEY_PORT_W-1:0] pick_key();
    if ($urandom_range(99) < 85) return key_pool[$urandom_range(KEY_POOL - 1)];
    return $urandom();
  endfunction

  // Sizes mostly fit a quarter of the budget; some overflow it
  function automatic logic [SIZE_W-1:0] pick_size(input logic [SPACE_W-1:0] budget);
    int r;
    logic [SIZE_W-1:0] quarter;
    r = $urandom_range(99);
    quarter = (budget >= 40'h3_FFFF_FFFC) ? 32'hFFFF_FFFF : 32'(budget >> 2);
    if (r < 8) return $urandom();
    if (r < 14 && budget < 40'hFFFF_FFFF) return 32'(budget) + 32'd1;
    return $urandom_range(quarter);
  endfunction

  initial begin
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = CFG_POLICY;
    cfg_wdata      = '0;
    in_valid       = 1'b0;
    in_key         = '0;
    in_object_size = '0;
    budget_now     = '1;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings: LRU, full budget, all ways; extreme keys and sizes
    send_access('0, '0);
    send_access('1, '1);
    send_access('0, 32'd5);
    send_access(32'd1, 32'd10);
    send_access(32'd2, 32'd20);
    drain();

    // Entry limit lowered below occupancy, then a hit that evicts nothing
    apply_settings(1'b0, '1, 5'd2);
    send_access(32'd3, 32'd1);
    send_access(32'd3, 32'd7);
    drain();

    // Entry limit of zero acts as one
    apply_settings(1'b0, '1, 5'd0);
    send_access(32'd4, 32'd2);
    drain();

    // MRU with a tight budget; limit above the way count; oversize object
    apply_settings(1'b1, 40'd100, 5'd31);
    send_access(32'd5, 32'd40);
    send_access(32'd6, 32'd40);
    send_access(32'd7, 32'd40);
    send_access(32'd8, 32'd200);
    send_access(32'd9, 32'd100);
    drain();

    // Zero budget: only empty objects fit
    apply_settings(1'b0, '0, 5'd16);
    send_access(32'd10, 32'd0);
    send_access(32'd11, 32'd1);
    send_access(32'd10, 32'd3);
    drain();

    // LRU eviction driven by space after a promoting hit
    apply_settings(1'b0, 40'd1000, 5'd16);
    send_access(32'd20, 32'd400);
    send_access(32'd21, 32'd400);
    send_access(32'd20, 32'd1);
    send_access(32'd22, 32'd300);
    drain();

    // Random phases, each with fresh settings and key pool
    for (int ph = 0; ph < RANDOM_ACCESSES / PHASE_LEN; ph++) begin
      for (int i = 0; i < KEY_POOL; i++) key_pool[i] = $urandom();
      roll = $urandom_range(99);
      if (roll < 15) budget_pick = '1;
      else if (roll < 50) budget_pick = 40'($urandom_range(4000, 1));
      else if (roll < 70) budget_pick = 40'($urandom_range(24'hFF_FFFF));
      else if (roll < 85) budget_pick = {8'($urandom()), 32'($urandom())};
      else if (roll < 92) budget_pick = '0;
      else budget_pick = 40'($urandom_range(50, 1));
      roll = $urandom_range(99);
      if (roll < 8) limit_pick = 5'd0;
      else if (roll < 16) limit_pick = 5'($urandom_range(31, 17));
      else if (roll < 30) limit_pick = 5'($urandom_range(2, 1));
      else limit_pick = 5'($urandom_range(16, 3));
      apply_settings(1'($urandom_range(1)), budget_pick, limit_pick);

      for (int j = 0; j < PHASE_LEN; j++) begin
        // Sender idles lightly first, then heavily, then neither side idles
        if (ph * PHASE_LEN + j < 150) begin
          send_idle_pct = 29;
          recv_idle_pct = 72;
        end else if (ph * PHASE_LEN + j < 300) begin
          send_idle_pct = 72;
          recv_idle_pct = 29;
        end else begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
        send_access(pick_key(), pick_size(budget_now));
      end
      drain();
    end

    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("cache_set_lru_mru_space_budget_tb: clean");
    end else begin
      $display("cache_set_lru_mru_space_budget_tb: errors");
    end
    $finish;
  end

endmodule
